FILE: design/deq_pkg.sv
package deq_pkg;

   localparam int FuncW        = 3;
   localparam int WordW        = 32;
   localparam int CountOutW    = 11;
   localparam int DefaultDepth = 1024;

   localparam logic [FuncW-1:0] FUNC_NONE       = 3'd0;
   localparam logic [FuncW-1:0] FUNC_PUSH_FRONT = 3'd1;
   localparam logic [FuncW-1:0] FUNC_PUSH_BACK  = 3'd2;
   localparam logic [FuncW-1:0] FUNC_POP_FRONT  = 3'd3;
   localparam logic [FuncW-1:0] FUNC_POP_BACK   = 3'd4;

   localparam logic signed [WordW-1:0] NegOne = '1;

   typedef struct packed {
      logic signed [WordW-1:0] popped;
      logic [CountOutW-1:0]    count;
      logic                    is_empty;
      logic signed [WordW-1:0] front_word;
      logic signed [WordW-1:0] back_word;
      logic                    overflow;
   } rsp_type;

endpackage

FILE: design/deq_req_if.sv
interface deq_req_if;
   logic                            valid;
   logic                            ready;
   logic [deq_pkg::FuncW-1:0]       func;
   logic signed [deq_pkg::WordW-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

FILE: design/deq_rsp_if.sv
interface deq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [deq_pkg::WordW-1:0] popped;
   logic [deq_pkg::CountOutW-1:0]    count;
   logic                             is_empty;
   logic signed [deq_pkg::WordW-1:0] front_word;
   logic signed [deq_pkg::WordW-1:0] back_word;
   logic                             overflow;

   modport source (output valid, output popped, output count, output is_empty,
                   output front_word, output back_word, output overflow, input ready);
   modport sink   (input valid, input popped, input count, input is_empty,
                   input front_word, input back_word, input overflow, output ready);
endinterface

FILE: design/double_ended_queue_core.sv
// Bounded double-ended queue of signed 32-bit words, DEPTH entries deep.
// req channel: one transfer carries func (query, push front, push back,
// pop front, pop back) and value. rsp channel: exactly one transfer per
// request, in order, carrying popped word, count, empty flag, front and back
// words (-1 when empty) and the overflow flag for a refused push.
// Words live in a single-port-read, single-port-write memory; the front and
// back words are cached in registers so queries and pushes need no read.
// Throughput: one request per cycle while the result buffer is not full,
// except a pop that leaves the queue non-empty: the new end word is fetched
// through the memory read port before the next request is taken.
// A result is written on acceptance, or in the read state for such a pop.
// Results go into a two-entry buffer, so a request is still taken while one
// result waits; req ready drops while both entries are occupied or an end
// word is being fetched, and nothing is lost while the receiver stalls.
// Reset: head and count cleared, back index set to the entry before head,
// result buffer emptied; the word memory is not cleared and needs no clearing.
module double_ended_queue_core #(
   parameter int DEPTH = deq_pkg::DefaultDepth
) (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req,
   deq_rsp_if.source rsp
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FullCount = CW'(DEPTH);
   localparam logic [IW-1:0] LastIdx   = IW'(DEPTH - 1);

   typedef enum logic {S_IDLE, S_READ} state_type;

   state_type                        state_ff, state_in;
   logic [IW-1:0]                    head_ff, head_in;
   logic [IW-1:0]                    back_idx_ff, back_idx_in;
   logic [CW-1:0]                    held_ff, held_in;
   logic signed [deq_pkg::WordW-1:0] front_ff, front_in;
   logic signed [deq_pkg::WordW-1:0] back_ff, back_in;
   logic                             pend_front_ff, pend_front_in;
   logic signed [deq_pkg::WordW-1:0] pend_popped_ff, pend_popped_in;

   logic                             accept, q_empty, q_full, buf_full, buf_wr;
   logic [IW-1:0]                    head_inc, head_dec, back_inc, back_dec;
   logic                             wr_en, rd_en;
   logic [IW-1:0]                    wr_addr, rd_addr;
   logic signed [deq_pkg::WordW-1:0] rd_data;
   logic signed [deq_pkg::WordW-1:0] popped;
   logic                             overflow;
   logic [CW+deq_pkg::CountOutW-1:0] count_wide;
   deq_pkg::rsp_type                 res;

   assign req.ready = (state_ff == S_IDLE) && !buf_full;
   assign accept    = req.valid && req.ready;
   assign q_empty   = (held_ff == '0);
   assign q_full    = (held_ff == FullCount);

   assign head_inc = (head_ff == LastIdx) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? LastIdx : head_ff - 1'b1;
   assign back_inc = (back_idx_ff == LastIdx) ? '0 : back_idx_ff + 1'b1;
   assign back_dec = (back_idx_ff == '0) ? LastIdx : back_idx_ff - 1'b1;

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      back_idx_in    = back_idx_ff;
      held_in        = held_ff;
      front_in       = front_ff;
      back_in        = back_ff;
      pend_front_in  = pend_front_ff;
      pend_popped_in = pend_popped_ff;
      wr_en          = 1'b0;
      wr_addr        = head_dec;
      rd_en          = 1'b0;
      rd_addr        = head_inc;
      popped         = deq_pkg::NegOne;
      overflow       = 1'b0;
      buf_wr         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               buf_wr = 1'b1;
               case (req.func)
                  deq_pkg::FUNC_PUSH_FRONT: begin
                     if (q_full) begin
                        overflow = 1'b1;
                     end else begin
                        head_in  = head_dec;
                        wr_en    = 1'b1;
                        wr_addr  = head_dec;
                        front_in = req.value;
                        held_in  = held_ff + 1'b1;
                        if (q_empty) begin
                           back_in = req.value;
                        end
                     end
                  end
                  deq_pkg::FUNC_PUSH_BACK: begin
                     if (q_full) begin
                        overflow = 1'b1;
                     end else begin
                        back_idx_in = back_inc;
                        wr_en       = 1'b1;
                        wr_addr     = back_inc;
                        back_in     = req.value;
                        held_in     = held_ff + 1'b1;
                        if (q_empty) begin
                           front_in = req.value;
                        end
                     end
                  end
                  deq_pkg::FUNC_POP_FRONT: begin
                     if (!q_empty) begin
                        popped  = front_ff;
                        head_in = head_inc;
                        held_in = held_ff - 1'b1;
                        if (held_ff != CW'(1)) begin
                           rd_en          = 1'b1;
                           rd_addr        = head_inc;
                           state_in       = S_READ;
                           pend_front_in  = 1'b1;
                           pend_popped_in = front_ff;
                           buf_wr         = 1'b0;
                        end
                     end
                  end
                  deq_pkg::FUNC_POP_BACK: begin
                     if (!q_empty) begin
                        popped      = back_ff;
                        back_idx_in = back_dec;
                        held_in     = held_ff - 1'b1;
                        if (held_ff != CW'(1)) begin
                           rd_en          = 1'b1;
                           rd_addr        = back_dec;
                           state_in       = S_READ;
                           pend_front_in  = 1'b0;
                           pend_popped_in = back_ff;
                           buf_wr         = 1'b0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            if (pend_front_ff) begin
               front_in = rd_data;
            end else begin
               back_in = rd_data;
            end
            popped   = pend_popped_ff;
            buf_wr   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign count_wide = {{deq_pkg::CountOutW{1'b0}}, held_in};

   always_comb begin
      res.popped     = popped;
      res.count      = count_wide[deq_pkg::CountOutW-1:0];
      res.is_empty   = (held_in == '0);
      res.front_word = (held_in == '0) ? deq_pkg::NegOne : front_in;
      res.back_word  = (held_in == '0) ? deq_pkg::NegOne : back_in;
      res.overflow   = overflow;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         head_ff     <= '0;
         back_idx_ff <= LastIdx;
         held_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         back_idx_ff <= back_idx_in;
         held_ff     <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff       <= front_in;
      back_ff        <= back_in;
      pend_front_ff  <= pend_front_in;
      pend_popped_ff <= pend_popped_in;
   end

   deq_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   deq_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (buf_wr),
      .wr_data  (res),
      .full     (buf_full),
      .rsp      (rsp)
   );

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= FullCount)
      else $error("held count beyond depth");

   a_empty_ring: assert property (@(posedge clock) disable iff (reset)
      (held_ff == '0) |-> (back_idx_ff == head_dec))
      else $error("back index not adjacent to head when empty");

   a_no_buf_overrun: assert property (@(posedge clock) disable iff (reset)
      buf_wr |-> !buf_full)
      else $error("result written into full buffer");

   a_refetch: assert property (@(posedge clock) disable iff (reset)
      (accept && held_ff > CW'(1) && (req.func == deq_pkg::FUNC_POP_FRONT ||
       req.func == deq_pkg::FUNC_POP_BACK)) |=> (state_ff == S_READ && !req.ready))
      else $error("pop leaving words did not refetch end word");

   a_read_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_IDLE))
      else $error("read state held more than one cycle");
`endif

endmodule

FILE: design/deq_ram.sv
module deq_ram #(
   parameter int  DEPTH = deq_pkg::DefaultDepth,
   localparam int IW    = $clog2(DEPTH)
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [IW-1:0]                    wr_addr,
   input  logic signed [deq_pkg::WordW-1:0] wr_data,
   input  logic                             rd_en,
   input  logic [IW-1:0]                    rd_addr,
   output logic signed [deq_pkg::WordW-1:0] rd_data
);

   logic signed [deq_pkg::WordW-1:0] store_ff [DEPTH];
   logic signed [deq_pkg::WordW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/deq_rsp_buf.sv
module deq_rsp_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   input  deq_pkg::rsp_type wr_data,
   output logic             full,
   deq_rsp_if.source        rsp
);

   deq_pkg::rsp_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       take;

   assign take = rsp.valid && rsp.ready;
   assign full = (cnt_ff == 2'd2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_valid) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (take) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({wr_valid, take})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rsp.valid      = (cnt_ff != 2'd0);
   assign rsp.popped     = entry_ff[rd_ptr_ff].popped;
   assign rsp.count      = entry_ff[rd_ptr_ff].count;
   assign rsp.is_empty   = entry_ff[rd_ptr_ff].is_empty;
   assign rsp.front_word = entry_ff[rd_ptr_ff].front_word;
   assign rsp.back_word  = entry_ff[rd_ptr_ff].back_word;
   assign rsp.overflow   = entry_ff[rd_ptr_ff].overflow;

endmodule
